### sv/rld_pkg.sv
// Shared types and constants of the block repeat decompressor.
package rld_pkg;

  // Default build parameters
  localparam int unsigned DEF_GROUP_DEPTH = 9;
  localparam int unsigned DEF_OUT_LANES   = 8;
  localparam int unsigned DEF_COUNT_WIDTH = 24;

  // Field and counter widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LIMIT_W = 24;
  localparam int unsigned GLEN_W  = 4;   // group length and fill, up to nine bytes
  localparam int unsigned REP_W   = 7;   // extra copies, up to 64
  localparam int unsigned BEAT_W  = 4;
  localparam int unsigned VB_W    = 4;
  localparam int unsigned OUT_W   = 64;

  // Most beats one input byte may cause
  localparam int unsigned MAX_BEATS = 10;

  // Header decode constants
  localparam logic [7:0] HDR_SINGLE  = 8'h80;  // first single repeat header
  localparam logic [7:0] SINGLE_BIAS = 8'h7F;  // single repeat copies = header - bias
  localparam logic [3:0] GRP_BASE    = 4'hB;   // group length base on the high nibble
  localparam logic [7:0] HI_MASK     = 8'hF0;
  localparam logic [7:0] LO_MASK     = 8'h0F;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 24'hFF_FFFF;

  // What one accepted data byte hands to the sequencer
  typedef struct packed {
    logic              data;      // byte is a data byte, not a header
    logic [GLEN_W-1:0] wr_idx;    // store entry that takes the byte
    logic [GLEN_W-1:0] last_idx;  // store entry that closes one pass
    logic [REP_W-1:0]  reps;      // passes over the store after the byte itself
  } step_t;

  // Sequencer to packer
  typedef struct packed {
    logic              start;
    logic              push;
    logic              fin;
    logic [BYTE_W-1:0] data;
  } pk_cmd_t;

endpackage

### sv/rld_parser.sv
// Header decoder and parser state of the block repeat decompressor.
module rld_parser
  import rld_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [BYTE_W-1:0] byte_in_i,
  input  logic              new_image_i,
  output step_t             step_o
);

  typedef enum logic [1:0] {
    KIND_LITERAL = 2'd0,
    KIND_SINGLE  = 2'd1,
    KIND_GROUP   = 2'd2
  } kind_e;

  logic              expect_q, expect_d;
  kind_e             kind_q, kind_d;
  logic [7:0]        left_q, left_d;
  logic [GLEN_W-1:0] glen_q, glen_d;
  logic [REP_W-1:0]  rep_q, rep_d;
  logic [GLEN_W-1:0] fill_q, fill_d;

  logic              eff_expect;
  kind_e             eff_kind;
  logic [GLEN_W-1:0] eff_fill;
  logic [3:0]        hi, lo;
  logic [7:0]        left_dec;
  logic              complete;

  // New image abandons whatever command was open
  assign eff_expect = new_image_i | expect_q;
  assign eff_kind   = new_image_i ? KIND_LITERAL : kind_q;
  assign eff_fill   = new_image_i ? '0 : fill_q;

  assign hi       = 4'((byte_in_i & HI_MASK) >> 4);
  assign lo       = 4'(byte_in_i & LO_MASK);
  assign left_dec = (left_q == 8'd0) ? 8'd0 : left_q - 8'd1;
  assign complete = ({1'b0, eff_fill} + 5'd1) >= {1'b0, glen_q};

  // Next parser state and the step handed to the sequencer
  always_comb begin
    expect_d = expect_q;
    kind_d   = kind_q;
    left_d   = left_q;
    glen_d   = glen_q;
    rep_d    = rep_q;
    fill_d   = eff_fill;
    step_o   = '0;
    if (eff_expect) begin
      expect_d = 1'b0;
      fill_d   = '0;
      if (byte_in_i < HDR_SINGLE) begin
        kind_d = KIND_LITERAL;
        left_d = byte_in_i + 8'd1;
      end else if (hi <= GRP_BASE) begin
        kind_d = KIND_SINGLE;
        glen_d = GLEN_W'(1);
        rep_d  = REP_W'(byte_in_i - SINGLE_BIAS);
      end else begin
        kind_d = KIND_GROUP;
        glen_d = ((hi - GRP_BASE) << 1) + {3'b000, lo[3]};
        rep_d  = {4'b0000, lo[2:0]} + REP_W'(1);
      end
    end else if (eff_kind == KIND_LITERAL) begin
      step_o.data = 1'b1;
      left_d      = left_dec;
      if (left_dec == 8'd0) begin
        expect_d = 1'b1;
      end
    end else begin
      step_o.data   = 1'b1;
      step_o.wr_idx = eff_fill;
      if (complete) begin
        step_o.last_idx = eff_fill;
        step_o.reps     = rep_q;
        expect_d        = 1'b1;
        fill_d          = '0;
      end else begin
        step_o.last_idx = eff_fill;
        fill_d          = eff_fill + GLEN_W'(1);
      end
    end
  end

  // Parser registers move only on an accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_q <= 1'b1;
      kind_q   <= KIND_LITERAL;
      left_q   <= '0;
      glen_q   <= '0;
      rep_q    <= '0;
      fill_q   <= '0;
    end else if (accept_i) begin
      expect_q <= expect_d;
      kind_q   <= kind_d;
      left_q   <= left_d;
      glen_q   <= glen_d;
      rep_q    <= rep_d;
      fill_q   <= fill_d;
    end
  end

endmodule

### sv/rld_packer.sv
// Byte packer and output register: gathers expanded bytes into beats.
module rld_packer
  import rld_pkg::*;
#(
  parameter int unsigned OUT_LANES = DEF_OUT_LANES
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  pk_cmd_t                  cmd_i,
  output logic                     stall_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [OUT_LANES*8-1:0]   out_data_o,
  output logic [VB_W-1:0]          out_count_o,
  output logic                     out_last_o
);

  localparam int unsigned CNT_W = $clog2(OUT_LANES + 1);

  logic [OUT_LANES-1:0][7:0] lanes_q;
  logic [CNT_W-1:0]          cnt_q;
  logic [BEAT_W-1:0]         beats_q;
  logic                      ovalid_q;
  logic [OUT_LANES*8-1:0]    obytes_q;
  logic [VB_W-1:0]           ocnt_q;
  logic                      olast_q;

  logic full, capped, out_free, push_spill, fin_send, send;

  assign full       = cnt_q == CNT_W'(OUT_LANES);
  assign capped     = beats_q == BEAT_W'(MAX_BEATS - 1);
  assign out_free   = !ovalid_q || out_ready_i;
  // A full beat leaves once another byte needs its room or the run finishes
  assign push_spill = cmd_i.push && full && !capped;
  assign fin_send   = cmd_i.fin && (cnt_q != '0);
  assign stall_o    = (push_spill || fin_send) && !out_free;
  assign send       = (push_spill || fin_send) && out_free;

  // Control: lane count, beat count, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      beats_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (send) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
      if (cmd_i.start) begin
        cnt_q   <= '0;
        beats_q <= '0;
      end else if (cmd_i.push && !stall_o) begin
        if (push_spill) begin
          cnt_q   <= CNT_W'(1);
          beats_q <= beats_q + BEAT_W'(1);
        end else if (!full) begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
      end else if (cmd_i.fin && !stall_o) begin
        cnt_q <= '0;
      end
    end
  end

  // Lane contents and output payload; unused lanes stay zero
  always_ff @(posedge clk_i) begin
    if (send) begin
      obytes_q <= lanes_q;
      ocnt_q   <= VB_W'(cnt_q);
      olast_q  <= cmd_i.fin;
    end
    if (cmd_i.start) begin
      lanes_q <= '0;
    end else if (cmd_i.push && !stall_o) begin
      if (push_spill) begin
        // new beat opens with this byte in lane 0
        lanes_q <= (OUT_LANES*8)'(cmd_i.data);
      end else begin
        for (int i = 0; i < OUT_LANES; i++) begin
          if (cnt_q == CNT_W'(i)) begin
            lanes_q[i] <= cmd_i.data;
          end
        end
      end
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = obytes_q;
  assign out_count_o = ocnt_q;
  assign out_last_o  = olast_q;

endmodule

### sv/block_repeat_decompressor.sv
// Top level of the block repeat decompressor: store, byte sequencer, limit counter.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_ready_o | byte_in_i, new_image_i
//   out     | output    | out_valid_o/out_ready_i | out_bytes_o, valid_bytes_o, last_of_run_o
//   cfg     | input     | cfg_valid_i/cfg_ready_o | output_limit_i
//
// A header byte leaves the sequencer idle, so input stays ready.
// A data byte takes the sequencer from idle to emit, which sends the N bytes it expands
// to below the limit, then to flush and back to idle; when the limit cuts off bytes still
// to come, emit sees the limit reached and moves to flush. The shared byte unit reads one
// group store entry and counts one byte a cycle while the packer does not stall; a beat
// handoff that waits on the held output register stalls it; input is not ready meanwhile.
// Reset is asynchronous; no clearing pass, the limit resets to its maximum.
module block_repeat_decompressor
  import rld_pkg::*;
#(
  parameter int unsigned GROUP_DEPTH = DEF_GROUP_DEPTH,
  parameter int unsigned OUT_LANES   = DEF_OUT_LANES,
  parameter int unsigned COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [BYTE_W-1:0]  byte_in_i,
  input  logic               new_image_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [OUT_W-1:0]   out_bytes_o,
  output logic [VB_W-1:0]    valid_bytes_o,
  output logic               last_of_run_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [LIMIT_W-1:0] output_limit_i
);

  localparam int unsigned IDX_W = $clog2(GROUP_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_EMIT  = 2'd1,
    ST_FLUSH = 2'd2
  } state_e;

  state_e                 state_q;
  logic [LIMIT_W-1:0]     limit_q;
  logic [COUNT_WIDTH-1:0] written_q;
  logic [IDX_W-1:0]       rp_q, last_q;
  logic [REP_W-1:0]       rep_left_q;
  logic [BYTE_W-1:0]      store_q [GROUP_DEPTH];

  logic                   accept;
  step_t                  step;
  pk_cmd_t                pk_cmd;
  logic                   pk_stall;
  logic [COUNT_WIDTH-1:0] limit_w;
  logic                   below_limit;
  logic [OUT_LANES*8-1:0] pk_data;

  assign in_ready_o  = state_q == ST_IDLE;
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign limit_w     = COUNT_WIDTH'(limit_q);
  assign below_limit = written_q < limit_w;

  rld_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .byte_in_i   (byte_in_i),
    .new_image_i (new_image_i),
    .step_o      (step)
  );

  // Limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= output_limit_i;
    end
  end

  // Group store: one write port, one read port at the sequencer pointer
  always_ff @(posedge clk_i) begin
    if (accept && step.data) begin
      store_q[IDX_W'(step.wr_idx)] <= byte_in_i;
    end
  end

  // Packer commands
  always_comb begin
    pk_cmd       = '0;
    pk_cmd.start = accept && step.data;
    pk_cmd.data  = store_q[rp_q];
    pk_cmd.push  = (state_q == ST_EMIT) && below_limit;
    pk_cmd.fin   = state_q == ST_FLUSH;
  end

  // Sequencer: walks the store one byte a cycle unless stalled, counts bytes against the limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      written_q  <= '0;
      rp_q       <= '0;
      last_q     <= '0;
      rep_left_q <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (new_image_i) begin
              written_q <= '0;
            end
            if (step.data) begin
              rp_q       <= IDX_W'(step.wr_idx);
              last_q     <= IDX_W'(step.last_idx);
              rep_left_q <= step.reps;
              state_q    <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (!below_limit) begin
            state_q <= ST_FLUSH;
          end else if (!pk_stall) begin
            written_q <= written_q + COUNT_WIDTH'(1);
            if (rp_q == last_q) begin
              if (rep_left_q == '0) begin
                state_q <= ST_FLUSH;
              end else begin
                rep_left_q <= rep_left_q - REP_W'(1);
                rp_q       <= '0;
              end
            end else begin
              rp_q <= rp_q + IDX_W'(1);
            end
          end
        end
        ST_FLUSH: begin
          if (!pk_stall) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  rld_packer #(
    .OUT_LANES (OUT_LANES)
  ) u_packer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (pk_cmd),
    .stall_o     (pk_stall),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (pk_data),
    .out_count_o (valid_bytes_o),
    .out_last_o  (last_of_run_o)
  );

  assign out_bytes_o = OUT_W'(pk_data);

endmodule

### sv/rld_checker.sv
// Port-level checks of the block repeat decompressor, bound to the top level.
module rld_checker
  import rld_pkg::*;
#(
  parameter int unsigned OUT_LANES = DEF_OUT_LANES
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic             new_image_i,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [OUT_W-1:0] out_bytes_o,
  input logic [VB_W-1:0]  valid_bytes_o,
  input logic             last_of_run_o
);

  // Stalled beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_bytes_o)
      && $stable(valid_bytes_o) && $stable(last_of_run_o))
    else $error("stalled output beat changed");

  // Only the closing beat of a byte may be partly filled
  a_full_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_run_o |-> valid_bytes_o == VB_W'(OUT_LANES))
    else $error("non-final beat not full");

  // Lanes above the valid count are zero
  a_upper_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && valid_bytes_o < 4'd8 |->
      (out_bytes_o >> {valid_bytes_o, 3'b000}) == '0)
    else $error("stale data above valid lanes");

  // A new image starts with a header, which leaves the block ready
  a_header_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && new_image_i |=> in_ready_o)
    else $error("not ready after new image header");

endmodule

bind block_repeat_decompressor rld_checker #(.OUT_LANES(OUT_LANES)) u_rld_checker (.*);
